>>> rtl/gdrc_pkg.sv
// ----------------------------------------------------------------------------
// gdrc_pkg
// Shared types, constants and codes of the grid DDA ray caster.
// ----------------------------------------------------------------------------
package gdrc_pkg;

  localparam int FRAC_BITS  = 11;
  localparam int DIR_FRAC   = 14;
  localparam int MAP_DIM    = 32;
  localparam int CELL_W     = $clog2(MAP_DIM);
  localparam int MAP_DEPTH  = MAP_DIM * MAP_DIM;
  localparam int ADDR_W     = 2 * CELL_W;
  localparam int GUARD_STEPS = 4 * MAP_DIM + 4;
  localparam int STEP_CNT_W = $clog2(GUARD_STEPS + 1);

  // camera division: (column << 15) / width ; delta division: 2^25 / |ray|
  localparam int NUM_W  = DIR_FRAC + FRAC_BITS + 1;
  localparam int DEN_W  = 27;
  localparam int RAY_W  = 28;
  localparam int CAM_W  = NUM_W + 1;
  localparam int SIDE_W = 49;
  localparam int MAPC_W = CELL_W + 2;
  localparam int DELTA_BIG_SH = 40;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 3'd6;

  localparam logic [15:0] RST_POS_X   = 16'd45056;
  localparam logic [15:0] RST_POS_Y   = 16'd24576;
  localparam logic [15:0] RST_DIR_X   = 16'hC000;
  localparam logic [15:0] RST_DIR_Y   = 16'd0;
  localparam logic [15:0] RST_PLANE_X = 16'd0;
  localparam logic [15:0] RST_PLANE_Y = 16'd10813;
  localparam logic [10:0] RST_SCREEN_W = 11'd640;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [9:0]  column;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [7:0]  cell_value;
  } in_item_t;

  typedef struct packed {
    logic [23:0] wall_dist;
    logic        wall_side;
    logic [4:0]  hit_x;
    logic [4:0]  hit_y;
    logic [7:0]  wall_value;
    logic        hit_flag;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DIV_CAM,
    OP_CAM,
    OP_RAY_X,
    OP_RAY_Y,
    OP_DIV_DX,
    OP_DX,
    OP_DIV_DY,
    OP_DY,
    OP_SIDE_X,
    OP_SIDE_Y,
    OP_STEP,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic leave;
    logic nonzero;
    logic guard_end;
  } stat_t;

endpackage

>>> rtl/grid_dda_ray_caster.sv
// ----------------------------------------------------------------------------
// grid_dda_ray_caster
// Fixed-point DDA ray caster over a 32 x 32 byte map.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): func 0 writes one map cell
// and gives no result; func 1 casts the ray for one screen column and gives
// one result on the output channel (out_valid / out_stall / out_data).
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the
// player position, view direction, camera plane and screen width; cfg_ready
// is always high, and writes are meant for when no cast is in flight.
// A cast runs three divisions on the shared restoring divider plus the ray
// and side set-up, then walks the grid one cell per step (at most 63 cells
// crossed) and offers its result once the output register is free.
// One item is worked at a time; in_stall is high from the cast until its
// result is in the output register.
// After reset the map store is cleared at one cell a cycle, with in_stall
// held high; registers that have reset values take them synchronously.
// A stalled result waits in the output register while the next item is
// taken; a further cast waits at its end until that register is free.
// ----------------------------------------------------------------------------
module grid_dda_ray_caster (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gdrc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gdrc_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gdrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);

  gdrc_pkg::cmd_t  cmd;
  gdrc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  gdrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  gdrc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

>>> rtl/gdrc_div.sv
// ----------------------------------------------------------------------------
// gdrc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdrc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gdrc_pkg::NUM_W-1:0]   num,
  input  logic [gdrc_pkg::DEN_W-1:0]   den,
  output logic [gdrc_pkg::NUM_W-1:0]   quo,
  output logic                         done
);

  localparam int NW = gdrc_pkg::NUM_W;
  localparam int DW = gdrc_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic [DW:0]   rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;

  always_comb begin
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt   = {q_r[NW-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      q_nxt   = {q_r[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

>>> rtl/gdrc_dp.sv
// ----------------------------------------------------------------------------
// gdrc_dp
// Datapath: config registers, map store, ray set-up and DDA walk.
// ----------------------------------------------------------------------------
module gdrc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gdrc_pkg::cmd_t                     cmd,
  output gdrc_pkg::stat_t                    stat,
  input  gdrc_pkg::in_item_t                 in_data,
  input  logic                               cfg_we,
  input  logic [gdrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data,
  output gdrc_pkg::out_item_t                out_data
);

  localparam int FB  = gdrc_pkg::FRAC_BITS;
  localparam int DF  = gdrc_pkg::DIR_FRAC;
  localparam int NW  = gdrc_pkg::NUM_W;
  localparam int DW  = gdrc_pkg::DEN_W;
  localparam int RW  = gdrc_pkg::RAY_W;
  localparam int CMW = gdrc_pkg::CAM_W;
  localparam int SW  = gdrc_pkg::SIDE_W;
  localparam int MW  = gdrc_pkg::MAPC_W;
  localparam int AW  = gdrc_pkg::ADDR_W;
  localparam int CLW = gdrc_pkg::CELL_W;
  localparam int GW  = gdrc_pkg::STEP_CNT_W;
  localparam int PW  = 16 + CMW;
  localparam int FW  = FB + 1;
  localparam int MPW = FW + NW;

  // configuration
  logic [15:0]        pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [10:0]        scr_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= gdrc_pkg::RST_POS_X;
      pos_y_r   <= gdrc_pkg::RST_POS_Y;
      dir_x_r   <= gdrc_pkg::RST_DIR_X;
      dir_y_r   <= gdrc_pkg::RST_DIR_Y;
      plane_x_r <= gdrc_pkg::RST_PLANE_X;
      plane_y_r <= gdrc_pkg::RST_PLANE_Y;
      scr_w_r   <= gdrc_pkg::RST_SCREEN_W;
    end else if (cfg_we) begin
      case (cfg_index)
        gdrc_pkg::CFG_POS_X:    pos_x_r   <= cfg_data;
        gdrc_pkg::CFG_POS_Y:    pos_y_r   <= cfg_data;
        gdrc_pkg::CFG_DIR_X:    dir_x_r   <= cfg_data;
        gdrc_pkg::CFG_DIR_Y:    dir_y_r   <= cfg_data;
        gdrc_pkg::CFG_PLANE_X:  plane_x_r <= cfg_data;
        gdrc_pkg::CFG_PLANE_Y:  plane_y_r <= cfg_data;
        gdrc_pkg::CFG_SCREEN_W: scr_w_r   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic [9:0]             column_r;
  logic signed [CMW-1:0]  cam_r;
  logic signed [RW-1:0]   rdx_r, rdy_r;
  logic [NW-1:0]          dqx_r, dqy_r;
  logic                   zx_r, zy_r;
  logic [SW-1:0]          sdx_r, sdy_r;
  logic signed [MW-1:0]   mx_r, my_r;
  logic                   side_r;
  logic [GW-1:0]          steps_r;
  logic [AW-1:0]          clr_r;
  logic [7:0]             rdata_r;
  gdrc_pkg::out_item_t    out_r;

  // map store
  logic [7:0] mem [gdrc_pkg::MAP_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    if (cmd.op == gdrc_pkg::OP_CLEAR) begin
      mem_we = 1'b1;
    end else if (cmd.op == gdrc_pkg::OP_LOAD && in_data.func == gdrc_pkg::FUNC_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = {in_data.cell_x[CLW-1:0], in_data.cell_y[CLW-1:0]};
      mem_wdata = in_data.cell_value;
    end
  end

  assign mem_raddr = {mx_r[CLW-1:0], my_r[CLW-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // divider operands
  logic          div_start;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [DW-1:0] magx, magy;
  logic [10:0]   scr_eff;

  assign scr_eff = (scr_w_r == '0) ? 11'd1 : scr_w_r;
  assign magx = rdx_r[RW-1] ? DW'(-rdx_r) : DW'(rdx_r);
  assign magy = rdy_r[RW-1] ? DW'(-rdy_r) : DW'(rdy_r);

  always_comb begin
    div_start = 1'b0;
    div_num   = NW'(1) << (DF + FB);
    div_den   = magx;
    case (cmd.op)
      gdrc_pkg::OP_DIV_CAM: begin
        div_start = 1'b1;
        div_num   = NW'({column_r, 1'b0}) << DF;
        div_den   = DW'(scr_eff);
      end
      gdrc_pkg::OP_DIV_DX: begin
        div_start = 1'b1;
      end
      gdrc_pkg::OP_DIV_DY: begin
        div_start = 1'b1;
        div_den   = magy;
      end
      default: ;
    endcase
  end

  gdrc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // ray and side distance arithmetic
  logic signed [PW-1:0]  prod_ray;
  logic signed [15:0]    plane_sel, dir_sel;
  logic signed [RW-1:0]  ray_nxt;
  logic                  neg_sel;
  logic [FB-1:0]         frac_sel;
  logic [FW-1:0]         f_sel;
  logic [NW-1:0]         dq_sel;
  logic                  z_sel;
  logic [MPW-1:0]        prod_side;
  logic [SW-1:0]         side_init;
  logic [SW-1:0]         ddx, ddy;
  logic [SW-1:0]         sdx_add, sdy_add;
  logic                  step_x;
  logic signed [MW-1:0]  mx_nxt, my_nxt;
  logic [SW-1:0]         dist_full;

  assign plane_sel = (cmd.op == gdrc_pkg::OP_RAY_Y) ? plane_y_r : plane_x_r;
  assign dir_sel   = (cmd.op == gdrc_pkg::OP_RAY_Y) ? dir_y_r : dir_x_r;
  assign prod_ray  = plane_sel * cam_r;
  assign ray_nxt   = RW'(dir_sel) + prod_ray[DF+RW-1:DF];

  assign neg_sel  = (cmd.op == gdrc_pkg::OP_SIDE_Y) ? rdy_r[RW-1] : rdx_r[RW-1];
  assign frac_sel = (cmd.op == gdrc_pkg::OP_SIDE_Y) ? pos_y_r[FB-1:0] : pos_x_r[FB-1:0];
  assign dq_sel   = (cmd.op == gdrc_pkg::OP_SIDE_Y) ? dqy_r : dqx_r;
  assign z_sel    = (cmd.op == gdrc_pkg::OP_SIDE_Y) ? zy_r : zx_r;
  assign f_sel    = neg_sel ? FW'(frac_sel) : (FW'(1) << FB) - FW'(frac_sel);
  assign prod_side = MPW'(f_sel) * MPW'(dq_sel);
  // an infinite delta is 2^40, so the product is a plain shift
  assign side_init = z_sel ? (SW'(f_sel) << (gdrc_pkg::DELTA_BIG_SH - FB))
                           : SW'(prod_side[MPW-1:FB]);

  assign ddx = zx_r ? (SW'(1) << gdrc_pkg::DELTA_BIG_SH) : SW'(dqx_r);
  assign ddy = zy_r ? (SW'(1) << gdrc_pkg::DELTA_BIG_SH) : SW'(dqy_r);
  assign sdx_add = sdx_r + ddx;
  assign sdy_add = sdy_r + ddy;
  assign step_x  = sdx_r < sdy_r;
  assign mx_nxt  = rdx_r[RW-1] ? mx_r - MW'(1) : mx_r + MW'(1);
  assign my_nxt  = rdy_r[RW-1] ? my_r - MW'(1) : my_r + MW'(1);
  assign dist_full = side_r ? sdy_r - ddy : sdx_r - ddx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.op == gdrc_pkg::OP_CLEAR) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      gdrc_pkg::OP_LOAD: begin
        column_r <= in_data.column;
        steps_r  <= '0;
        side_r   <= 1'b0;
        mx_r     <= MW'(pos_x_r[15:FB]);
        my_r     <= MW'(pos_y_r[15:FB]);
      end
      gdrc_pkg::OP_CAM:   cam_r <= CMW'(div_quo) - (CMW'(1) << DF);
      gdrc_pkg::OP_RAY_X: rdx_r <= ray_nxt;
      gdrc_pkg::OP_RAY_Y: rdy_r <= ray_nxt;
      gdrc_pkg::OP_DX: begin
        dqx_r <= div_quo;
        zx_r  <= (rdx_r == '0);
      end
      gdrc_pkg::OP_DY: begin
        dqy_r <= div_quo;
        zy_r  <= (rdy_r == '0);
      end
      gdrc_pkg::OP_SIDE_X: sdx_r <= side_init;
      gdrc_pkg::OP_SIDE_Y: sdy_r <= side_init;
      gdrc_pkg::OP_STEP: begin
        steps_r <= steps_r + 1'b1;
        if (step_x) begin
          sdx_r  <= sdx_add;
          mx_r   <= mx_nxt;
          side_r <= 1'b0;
        end else begin
          sdy_r  <= sdy_add;
          my_r   <= my_nxt;
          side_r <= 1'b1;
        end
      end
      gdrc_pkg::OP_RESULT: begin
        out_r.wall_dist  <= (|dist_full[SW-1:24]) ? 24'hFFFFFF : dist_full[23:0];
        out_r.wall_side  <= side_r;
        out_r.hit_x      <= mx_r[4:0];
        out_r.hit_y      <= my_r[4:0];
        out_r.hit_flag   <= !stat.leave && stat.nonzero;
        out_r.wall_value <= (!stat.leave && stat.nonzero) ? rdata_r : 8'd0;
      end
      default: ;
    endcase
  end

  assign stat.clr_last  = (clr_r == AW'(gdrc_pkg::MAP_DEPTH - 1));
  assign stat.div_done  = div_done;
  assign stat.leave     = mx_r[MW-1] || my_r[MW-1] || mx_r[MW-2] || my_r[MW-2];
  assign stat.nonzero   = (rdata_r != 8'd0);
  assign stat.guard_end = (steps_r == GW'(gdrc_pkg::GUARD_STEPS));

  assign out_data = out_r;

endmodule

>>> rtl/gdrc_ctrl.sv
// ----------------------------------------------------------------------------
// gdrc_ctrl
// Sequencer for map clear, ray set-up, DDA walk and result hand-off.
// ----------------------------------------------------------------------------
module gdrc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_func,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  gdrc_pkg::stat_t stat,
  output gdrc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CAM_GO, S_CAM_WAIT, S_RAY_X, S_RAY_Y,
    S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT, S_SIDE_X, S_SIDE_Y,
    S_CHECK, S_LOOK, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, out_free;
  // LOOK after CHECK tests the cell; LOOK after set-up only steps
  logic   tested_r;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = gdrc_pkg::OP_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd.op = gdrc_pkg::OP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.op = gdrc_pkg::OP_LOAD;
          if (in_func == gdrc_pkg::FUNC_CAST) state_nxt = S_CAM_GO;
        end
      end
      S_CAM_GO: begin
        cmd.op    = gdrc_pkg::OP_DIV_CAM;
        state_nxt = S_CAM_WAIT;
      end
      S_CAM_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = gdrc_pkg::OP_CAM;
          state_nxt = S_RAY_X;
        end
      end
      S_RAY_X: begin
        cmd.op    = gdrc_pkg::OP_RAY_X;
        state_nxt = S_RAY_Y;
      end
      S_RAY_Y: begin
        cmd.op    = gdrc_pkg::OP_RAY_Y;
        state_nxt = S_DX_GO;
      end
      S_DX_GO: begin
        cmd.op    = gdrc_pkg::OP_DIV_DX;
        state_nxt = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = gdrc_pkg::OP_DX;
          state_nxt = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd.op    = gdrc_pkg::OP_DIV_DY;
        state_nxt = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = gdrc_pkg::OP_DY;
          state_nxt = S_SIDE_X;
        end
      end
      S_SIDE_X: begin
        cmd.op    = gdrc_pkg::OP_SIDE_X;
        state_nxt = S_SIDE_Y;
      end
      S_SIDE_Y: begin
        cmd.op    = gdrc_pkg::OP_SIDE_Y;
        state_nxt = S_LOOK;
      end
      S_CHECK: begin
        // the map read for the new cell lands at this edge
        state_nxt = stat.leave ? S_FIN : S_LOOK;
      end
      S_LOOK: begin
        // first pass comes straight from set-up: the start cell is not tested
        if (tested_r && (stat.nonzero || stat.guard_end)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHECK;
          cmd.op    = gdrc_pkg::OP_STEP;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op        = gdrc_pkg::OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      tested_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tested_r    <= (state_r == S_CHECK);
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/gdrc_checker.sv
// ----------------------------------------------------------------------------
// gdrc_checker
// Port-level checks of the ray caster, bound to the top level.
// ----------------------------------------------------------------------------
module gdrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input gdrc_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input gdrc_pkg::out_item_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // a cast request blocks the input for at least the next cycle
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.func == gdrc_pkg::FUNC_CAST |=> in_stall)
    else $error("input taken during a cast");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit_flag |-> out_data.wall_value == 8'd0)
    else $error("value on a miss");

  a_hit_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit_flag |-> out_data.wall_value != 8'd0)
    else $error("hit on an empty cell");

endmodule

bind grid_dda_ray_caster gdrc_checker u_gdrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
